### rtl/core/matrix4x4_multiply_core_assert.svh
// Assertion macros for the matrix multiply core.
// Used by files that include it; they must have i_clk and i_rst_n in scope.
`ifndef MATRIX4X4_MULTIPLY_CORE_ASSERT_SVH
`define MATRIX4X4_MULTIPLY_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MM4X4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define MM4X4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mm4x4_pkg.sv
// Shared types and constants for the matrix multiply core.
// No dependencies; used by every module of the core but mm4x4_store.
`timescale 1ns / 1ps

package mm4x4_pkg;

    // Default sizes
    localparam int DEF_MATRIX_DIM    = 4;
    localparam int DEF_FRACTION_BITS = 16;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int VALUE_W = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // Saturation limits
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    // Input word
    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [IDX_W-1:0]          element_index;
        logic signed [VALUE_W-1:0] element_value;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [IDX_W-1:0]          result_index;
        logic signed [VALUE_W-1:0] result_value;
        logic                      last_result;
    } t_out_word;

    // Control traveling alongside each multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;      // first term of a dot product
        logic             last_k;     // last term of a dot product
        logic [IDX_W-1:0] index;      // product element index
        logic             last_elem;  // final product element
    } t_mac_tag;

endpackage

### rtl/core/mm4x4_store.sv
// Matrix element store: one write port, one registered read port.
// Entries read as zero until written since reset. Uses mm4x4_pkg nothing.
`timescale 1ns / 1ps

module mm4x4_store #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_hit;

    // Storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Written-since-reset flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_hit <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

### rtl/core/mm4x4_seq.sv
// Compute sequencer: walks column, row and term, issuing store reads.
// Depends on mm4x4_pkg for the step tag.
`timescale 1ns / 1ps

module mm4x4_seq #(
    parameter int MATRIX_DIM = mm4x4_pkg::DEF_MATRIX_DIM,
    localparam int ADDR_W = $clog2(MATRIX_DIM * MATRIX_DIM)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    output logic [ADDR_W-1:0]   o_addr_a,
    output logic [ADDR_W-1:0]   o_addr_b,
    output mm4x4_pkg::t_mac_tag o_tag
);

    localparam int DIM_W = $clog2(MATRIX_DIM);
    localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MATRIX_DIM - 1);

    logic             r_run, n_run;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_k, n_k;
    logic             w_k_end, w_row_end, w_col_end;

    assign w_k_end   = (r_k == DIM_LAST);
    assign w_row_end = (r_row == DIM_LAST);
    assign w_col_end = (r_col == DIM_LAST);

    // Counter advance: term fastest, then row, then column
    always_comb begin
        n_run = r_run;
        n_col = r_col;
        n_row = r_row;
        n_k   = r_k;
        if (i_go) begin
            n_run = 1'b1;
            n_col = '0;
            n_row = '0;
            n_k   = '0;
        end else if (r_run) begin
            if (w_k_end) begin
                n_k = '0;
                if (w_row_end) begin
                    n_row = '0;
                    if (w_col_end) begin
                        n_col = '0;
                        n_run = 1'b0;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_k = r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_col <= '0;
            r_row <= '0;
            r_k   <= '0;
        end else begin
            r_run <= n_run;
            r_col <= n_col;
            r_row <= n_row;
            r_k   <= n_k;
        end
    end

    // A[k*D+r], B[c*D+k]
    assign o_addr_a = ADDR_W'(r_k) * ADDR_W'(MATRIX_DIM) + ADDR_W'(r_row);
    assign o_addr_b = ADDR_W'(r_col) * ADDR_W'(MATRIX_DIM) + ADDR_W'(r_k);

    always_comb begin
        o_tag.valid     = r_run;
        o_tag.first     = (r_k == '0);
        o_tag.last_k    = w_k_end;
        o_tag.index     = mm4x4_pkg::IDX_W'(ADDR_W'(r_col) * ADDR_W'(MATRIX_DIM)
                                            + ADDR_W'(r_row));
        o_tag.last_elem = w_col_end && w_row_end;
    end

endmodule

### rtl/core/mm4x4_mac.sv
// Multiply-accumulate datapath: multiply, floor shift, accumulate, saturate.
// Depends on mm4x4_pkg for the step tag and result word.
`timescale 1ns / 1ps

module mm4x4_mac #(
    parameter int MATRIX_DIM    = mm4x4_pkg::DEF_MATRIX_DIM,
    parameter int FRACTION_BITS = mm4x4_pkg::DEF_FRACTION_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mm4x4_pkg::t_mac_tag                 i_tag,
    input  logic [mm4x4_pkg::VALUE_W-1:0]       i_a,
    input  logic [mm4x4_pkg::VALUE_W-1:0]       i_b,
    output logic                                o_strobe,
    output mm4x4_pkg::t_out_word                o_result
);

    localparam int VW      = mm4x4_pkg::VALUE_W;
    localparam int PROD_W  = 2 * VW;
    localparam int SHIFT_W = PROD_W - FRACTION_BITS;
    localparam int SUM_W   = SHIFT_W + $clog2(MATRIX_DIM);

    mm4x4_pkg::t_mac_tag      r_tag1, r_tag2, r_tag3;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc, n_acc;
    logic signed [SHIFT_W-1:0] w_shifted;
    logic signed [SUM_W-1:0]  w_term;
    logic                     w_fits;
    logic [VW-1:0]            w_sat;
    logic                     r_strobe;
    mm4x4_pkg::t_out_word     r_result;

    // Tag pipeline: aligns with read data, product, then accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1   <= '0;
            r_tag2   <= '0;
            r_tag3   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_tag1   <= i_tag;
            r_tag2   <= r_tag1;
            r_tag3   <= r_tag2;
            r_strobe <= r_tag3.valid && r_tag3.last_k;
        end
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_a) * $signed(i_b);
    end

    // Floor shift is the arithmetic shift; sign-extend to the sum width
    assign w_shifted = r_prod[PROD_W-1:FRACTION_BITS];
    assign w_term    = {{(SUM_W - SHIFT_W){w_shifted[SHIFT_W-1]}}, w_shifted};

    always_comb begin
        n_acc = r_acc;
        if (r_tag2.valid) begin
            n_acc = r_tag2.first ? w_term : r_acc + w_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Saturate: fits when all bits above the 32-bit sign agree
    assign w_fits = (r_acc[SUM_W-1:VW-1] == '0) || (r_acc[SUM_W-1:VW-1] == '1);
    assign w_sat  = w_fits ? r_acc[VW-1:0]
                  : (r_acc[SUM_W-1] ? mm4x4_pkg::VALUE_MIN : mm4x4_pkg::VALUE_MAX);

    // Result word register
    always_ff @(posedge i_clk) begin
        r_result.result_index <= r_tag3.index;
        r_result.result_value <= w_sat;
        r_result.last_result  <= r_tag3.last_elem;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### rtl/core/matrix4x4_multiply_core.sv
// Top level of the matrix multiply core: command decode, stores, sequencer, datapath.
// Depends on mm4x4_pkg, mm4x4_store, mm4x4_seq, mm4x4_mac and the assertion header.
`timescale 1ns / 1ps

// Square matrix multiply P = A * B in signed Q16.16, column-major, with both
// stores zero after reset. A word is taken when start is high and busy is low.
// Loading an element of A or B leaves busy low, so loads may follow each
// other every cycle. A compute word raises busy until the final element
// is out: the datapath does one multiply-accumulate per cycle, one read
// from each store's single read port, and the pipeline from read to result
// register is four deep. The product elements come out in ascending index
// order, each on o_result for exactly one cycle marked by o_strobe; the
// receiver cannot stall them, so it must take every strobed word. The final
// element carries last_result, and busy drops at the end of that cycle.
// Operation code 3 and loads to an index outside the matrix are dropped.

`include "matrix4x4_multiply_core_assert.svh"

module matrix4x4_multiply_core #(
    parameter int MATRIX_DIM    = mm4x4_pkg::DEF_MATRIX_DIM,
    parameter int FRACTION_BITS = mm4x4_pkg::DEF_FRACTION_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mm4x4_pkg::t_in_word  i_cmd,
    output logic                 o_strobe,
    output mm4x4_pkg::t_out_word o_result
);

    localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
    localparam int ADDR_W     = $clog2(ELEM_COUNT);

    logic                            r_busy, n_busy;
    logic                            w_accept;
    logic                            w_in_range;
    logic                            w_go;
    logic                            w_we_a, w_we_b;
    logic [ADDR_W-1:0]               w_wr_addr;
    logic [ADDR_W-1:0]               w_addr_a, w_addr_b;
    logic [mm4x4_pkg::VALUE_W-1:0]   w_data_a, w_data_b;
    mm4x4_pkg::t_mac_tag             w_tag;

    // Command decode
    assign w_accept   = start && !r_busy;
    assign w_in_range = (32'(i_cmd.element_index) < 32'(ELEM_COUNT));
    assign w_wr_addr  = ADDR_W'(i_cmd.element_index);
    assign w_we_a     = w_accept && w_in_range && (i_cmd.operation == mm4x4_pkg::OP_LOAD_A);
    assign w_we_b     = w_accept && w_in_range && (i_cmd.operation == mm4x4_pkg::OP_LOAD_B);
    assign w_go       = w_accept && (i_cmd.operation == mm4x4_pkg::OP_COMPUTE);

    // Busy from compute accept until the final word goes out
    always_comb begin
        n_busy = r_busy;
        if (w_go) begin
            n_busy = 1'b1;
        end else if (o_strobe && o_result.last_result) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    assign busy = r_busy;

    // Left matrix store
    mm4x4_store #(
        .DEPTH  (ELEM_COUNT),
        .DATA_W (mm4x4_pkg::VALUE_W)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_we_a),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_cmd.element_value),
        .i_rd_addr (w_addr_a),
        .o_rd_data (w_data_a)
    );

    // Right matrix store
    mm4x4_store #(
        .DEPTH  (ELEM_COUNT),
        .DATA_W (mm4x4_pkg::VALUE_W)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_we_b),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_cmd.element_value),
        .i_rd_addr (w_addr_b),
        .o_rd_data (w_data_b)
    );

    // Read sequencer
    mm4x4_seq #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .o_addr_a (w_addr_a),
        .o_addr_b (w_addr_b),
        .o_tag    (w_tag)
    );

    // Datapath
    mm4x4_mac #(
        .MATRIX_DIM    (MATRIX_DIM),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_tag),
        .i_a      (w_data_a),
        .i_b      (w_data_b),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Checks
    `MM4X4_ASSERT_NOW(a_strobe_while_busy, o_strobe, r_busy, "result word outside a compute")
    `MM4X4_ASSERT_NEXT(a_idle_after_last, o_strobe && o_result.last_result, !r_busy, "busy held after final word")
    `MM4X4_ASSERT_NEXT(a_strobe_spacing, o_strobe, !o_strobe, "result words back to back")
    `MM4X4_ASSERT_NEXT(a_go_sets_busy, w_go, r_busy, "compute accepted without busy")
    `MM4X4_ASSERT_NOW(a_no_write_in_compute, r_busy, !w_we_a && !w_we_b, "store written during compute")

endmodule
